/* hdl/chip8_instruction_execute_assert.svh */
// assertion macros shared by the chip8 execute modules
// no dependencies
`ifndef CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
// implication checked every clock outside reset
`define C8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define C8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/c8exe_pkg.sv */
// package for the chip8 execute unit: constants, command and status types
// no dependencies
package c8exe_pkg;

  localparam int DefStackDepth = 16;
  localparam int DefMemBytes   = 4096;

  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // configuration register indexes
  localparam logic CFG_VF_RESET = 1'b0;
  localparam logic CFG_JUMP_VX  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNKNOWN   = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;

  localparam logic [15:0] OPC_CLS  = 16'h00E0;
  localparam logic [15:0] OPC_RET  = 16'h00EE;
  localparam logic [15:0] OPC_EXIT = 16'h00FD;
  localparam logic [15:0] OPC_HIGH = 16'h00FF;
  localparam logic [15:0] OPC_LOW  = 16'h00FE;

  localparam logic [7:0] NN_SKP  = 8'h9E;
  localparam logic [7:0] NN_SKNP = 8'hA1;
  localparam logic [7:0] NN_GDT  = 8'h07;
  localparam logic [7:0] NN_KEY  = 8'h0A;
  localparam logic [7:0] NN_SDT  = 8'h15;
  localparam logic [7:0] NN_SST  = 8'h18;
  localparam logic [7:0] NN_ADDI = 8'h1E;
  localparam logic [7:0] NN_FONT = 8'h29;
  localparam logic [7:0] NN_BCD  = 8'h33;
  localparam logic [7:0] NN_STR  = 8'h55;
  localparam logic [7:0] NN_LDR  = 8'h65;

  localparam logic [15:0] FONT_BASE = 16'h0050;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       exec;      // single-cycle opcode apply
    logic       bcd;       // bcd digit write step
    logic       blk_st;    // block store step
    logic       blk_ld_rd; // block load memory read
    logic       blk_ld_wr; // block load register write
    logic       blk_done;  // advance I after block op
    logic [4:0] step;      // block / bcd step
  } c8exe_cmd_t;

  typedef struct packed {
    logic       halted;
    logic [3:0] x;
  } c8exe_sts_t;

endpackage

/* hdl/c8exe_ctrl.sv */
// controller for the chip8 execute unit: sequences multi-cycle opcodes
// depends on c8exe_pkg
module c8exe_ctrl import c8exe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [15:0] in_opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  c8exe_sts_t sts,
  output c8exe_cmd_t cmd,
  output logic       capture
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BCD  = 3'd1;
  localparam logic [2:0] S_ST   = 3'd2;
  localparam logic [2:0] S_LDR  = 3'd3;
  localparam logic [2:0] S_LDW  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       accept;
  logic       is_multi_st, is_multi_ld, is_bcd;

  assign in_ready  = (state_r == S_IDLE) && !out_valid;
  assign accept    = in_valid && in_ready;
  assign is_bcd    = in_operation == OP_EXEC && !sts.halted &&
                     in_opcode[15:12] == 4'hF && in_opcode[7:0] == NN_BCD;
  assign is_multi_st = in_operation == OP_EXEC && !sts.halted &&
                       in_opcode[15:12] == 4'hF && in_opcode[7:0] == NN_STR;
  assign is_multi_ld = in_operation == OP_EXEC && !sts.halted &&
                       in_opcode[15:12] == 4'hF && in_opcode[7:0] == NN_LDR;

  logic out_valid_r, out_valid_nxt;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step      = step_r;
    capture       = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          if (is_bcd) begin
            state_nxt = S_BCD;
          end else if (is_multi_st) begin
            state_nxt = S_ST;
          end else if (is_multi_ld) begin
            state_nxt = S_LDR;
          end else begin
            cmd.exec = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_BCD: begin
        cmd.bcd  = 1'b1;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd2) state_nxt = S_OUT;
      end
      S_ST: begin
        cmd.blk_st = 1'b1;
        step_nxt   = step_r + 5'd1;
        if (step_r[3:0] == sts.x) begin
          cmd.blk_done = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_LDR: begin
        cmd.blk_ld_rd = 1'b1;
        state_nxt     = S_LDW;
      end
      S_LDW: begin
        cmd.blk_ld_wr = 1'b1;
        step_nxt      = step_r + 5'd1;
        if (step_r[3:0] == sts.x) begin
          cmd.blk_done = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_LDR;
        end
      end
      S_OUT: begin
        capture       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `include "chip8_instruction_execute_assert.svh"
  `C8_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready, "accept while busy")
  `C8_ASSERT_NEXT(a_out_after, state_r == S_OUT, out_valid, "no result after capture")
  `C8_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.exec, cmd.bcd, cmd.blk_st,
                 cmd.blk_ld_rd, cmd.blk_ld_wr}), "multiple commands")

endmodule

/* hdl/c8exe_dp.sv */
// datapath for the chip8 execute unit: registers, stack, memory, alu
// depends on c8exe_pkg
module c8exe_dp import c8exe_pkg::*; #(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int MEM_BYTES   = DefMemBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_key_bits,
  input  logic [7:0]  in_random_byte,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  input  logic        vf_reset_quirk,
  input  logic        jump_uses_vx,
  input  c8exe_cmd_t  cmd,
  input  logic        capture,
  output c8exe_sts_t  sts,
  output logic [15:0] out_program_counter,
  output logic [15:0] out_index_value,
  output logic [2:0]  out_status,
  output logic        out_clear_screen,
  output logic        out_draw_request,
  output logic [7:0]  out_draw_x,
  output logic [7:0]  out_draw_y,
  output logic [3:0]  out_draw_rows,
  output logic        out_high_res,
  output logic        out_sound_on,
  output logic        out_waiting_key
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]  v_r [16];
  logic [15:0] i_r, pc_r;
  logic [CW-1:0] sp_r;
  logic [7:0]  dt_r, st_r;
  logic        hires_r, halt_r;
  logic [15:0] stack_mem [STACK_DEPTH];
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_q;
  logic [15:0] stack_q;

  // latched item
  logic [15:0] opc_r;
  logic [2:0]  stat_r;
  logic        clr_r, draw_r, wait_r;
  logic [7:0]  dx_r, dy_r;

  logic [3:0] x, y, n;
  logic [7:0] nn, vx, vy;
  assign x  = in_opcode[11:8];
  assign y  = in_opcode[7:4];
  assign n  = in_opcode[3:0];
  assign nn = in_opcode[7:0];
  assign vx = v_r[x];
  assign vy = v_r[y];

  assign sts.halted = halt_r;
  assign sts.x      = opc_r[11:8];

  // exec decode
  logic [15:0] pc2, pc_new, i_new;
  logic [7:0]  vx_new, vf_new, dt_new, st_new;
  logic        vx_we, vf_we, push, pop, hires_new, halt_new;
  logic [2:0]  stat_new;
  logic        clr_new, draw_new, wait_new;
  logic [8:0]  sum9;
  logic [3:0]  first_key;
  logic        any_key;

  always_comb begin
    first_key = 4'd0;
    any_key   = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (in_key_bits[k]) begin
        first_key = 4'(k);
        any_key   = 1'b1;
      end
    end
  end

  always_comb begin
    pc2       = pc_r + 16'd2;
    pc_new    = pc2;
    i_new     = i_r;
    vx_new    = vx;
    vf_new    = 8'd0;
    vx_we     = 1'b0;
    vf_we     = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    hires_new = hires_r;
    halt_new  = halt_r;
    dt_new    = dt_r;
    st_new    = st_r;
    stat_new  = ST_OK;
    clr_new   = 1'b0;
    draw_new  = 1'b0;
    wait_new  = 1'b0;
    sum9      = {1'b0, vx} + {1'b0, vy};
    unique case (in_opcode[15:12])
      4'h0: begin
        if (in_opcode == OPC_CLS) clr_new = 1'b1;
        else if (in_opcode == OPC_RET) begin
          if (sp_r == '0) stat_new = ST_UNDERFLOW;
          else pop = 1'b1;
        end else if (in_opcode == OPC_EXIT) halt_new = 1'b1;
        else if (in_opcode == OPC_HIGH) hires_new = 1'b1;
        else if (in_opcode == OPC_LOW) hires_new = 1'b0;
        else stat_new = ST_UNKNOWN;
      end
      4'h1: pc_new = {4'd0, in_opcode[11:0]};
      4'h2: begin
        if (sp_r >= CW'(STACK_DEPTH)) stat_new = ST_OVERFLOW;
        else begin
          push   = 1'b1;
          pc_new = {4'd0, in_opcode[11:0]};
        end
      end
      4'h3: if (vx == nn) pc_new = pc_r + 16'd4;
      4'h4: if (vx != nn) pc_new = pc_r + 16'd4;
      4'h5: if (vx == vy) pc_new = pc_r + 16'd4;
      4'h6: begin vx_we = 1'b1; vx_new = nn; end
      4'h7: begin vx_we = 1'b1; vx_new = vx + nn; end
      4'h8: begin
        vx_we = 1'b1;
        case (n)
          4'h0: vx_new = vy;
          4'h1: begin vx_new = vx | vy; vf_we = vf_reset_quirk; end
          4'h2: begin vx_new = vx & vy; vf_we = vf_reset_quirk; end
          4'h3: begin vx_new = vx ^ vy; vf_we = vf_reset_quirk; end
          4'h4: begin vx_new = sum9[7:0]; vf_we = 1'b1; vf_new = {7'd0, sum9[8]}; end
          4'h5: begin vx_new = vx - vy; vf_we = 1'b1; vf_new = {7'd0, vx >= vy}; end
          4'h6: begin vx_new = {1'b0, vy[7:1]}; vf_we = 1'b1; vf_new = {7'd0, vy[0]}; end
          4'h7: begin vx_new = vy - vx; vf_we = 1'b1; vf_new = {7'd0, vy >= vx}; end
          4'hE: begin vx_new = {vy[6:0], 1'b0}; vf_we = 1'b1; vf_new = {7'd0, vy[7]}; end
          default: begin vx_we = 1'b0; stat_new = ST_UNKNOWN; end
        endcase
      end
      4'h9: if (vx != vy) pc_new = pc_r + 16'd4;
      4'hA: i_new = {4'd0, in_opcode[11:0]};
      4'hB: pc_new = {4'd0, in_opcode[11:0]} + {8'd0, (jump_uses_vx ? vx : v_r[0])};
      4'hC: begin vx_we = 1'b1; vx_new = in_random_byte & nn; end
      4'hD: draw_new = 1'b1;
      4'hE: begin
        if (nn == NN_SKP) begin
          if (in_key_bits[vx[3:0]]) pc_new = pc_r + 16'd4;
        end else if (nn == NN_SKNP) begin
          if (!in_key_bits[vx[3:0]]) pc_new = pc_r + 16'd4;
        end else stat_new = ST_UNKNOWN;
      end
      default: begin
        unique case (nn)
          NN_GDT: begin vx_we = 1'b1; vx_new = dt_r; end
          NN_KEY: begin
            if (any_key) begin vx_we = 1'b1; vx_new = {4'd0, first_key}; end
            else begin pc_new = pc_r; wait_new = 1'b1; end
          end
          NN_SDT:  dt_new = vx;
          NN_SST:  st_new = vx;
          NN_ADDI: i_new = i_r + {8'd0, vx};
          NN_FONT: i_new = FONT_BASE + {6'd0, vx, 2'd0} + {8'd0, vx};
          default: stat_new = ST_UNKNOWN;
        endcase
      end
    endcase
  end

  // bcd digit by step: compare and subtract for hundreds, reciprocal multiply for tens
  logic [7:0]  bcd_d;
  logic [7:0]  vxs;
  logic [7:0]  bcd_hund, bcd_rem, bcd_tens, bcd_ones;
  logic [15:0] bcd_prod;
  assign vxs = v_r[opc_r[11:8]];
  always_comb begin
    if (vxs >= 8'd200) begin
      bcd_hund = 8'd2;
      bcd_rem  = vxs - 8'd200;
    end else if (vxs >= 8'd100) begin
      bcd_hund = 8'd1;
      bcd_rem  = vxs - 8'd100;
    end else begin
      bcd_hund = 8'd0;
      bcd_rem  = vxs;
    end
    // rem * 205 >> 11 gives rem / 10 for rem below 100
    bcd_prod = {8'd0, bcd_rem} * 16'd205;
    bcd_tens = {3'd0, bcd_prod[15:11]};
    bcd_ones = bcd_rem - {bcd_tens[4:0], 3'd0} - {bcd_tens[6:0], 1'b0};
    case (cmd.step[1:0])
      2'd0:    bcd_d = bcd_hund;
      2'd1:    bcd_d = bcd_tens;
      default: bcd_d = bcd_ones;
    endcase
  end

  logic [15:0] blk_addr16;
  logic [AW-1:0] blk_addr;
  assign blk_addr16 = i_r + {11'd0, cmd.step};
  assign blk_addr   = blk_addr16[AW-1:0];

  // memory port
  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_LOAD)
      mem[AW'(in_load_address)] <= in_load_byte;
    else if (cmd.bcd)
      mem[blk_addr] <= bcd_d;
    else if (cmd.blk_st)
      mem[blk_addr] <= v_r[cmd.step[3:0]];
    mem_q <= mem[blk_addr];
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_EXEC && !halt_r && push)
      stack_mem[sp_r[SW-1:0]] <= pc2;
  end
  assign stack_q = stack_mem[SW'(sp_r - CW'(1))];

  logic do_exec;
  assign do_exec = cmd.exec && in_operation == OP_EXEC && !halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) v_r[k] <= 8'd0;
      i_r     <= 16'd0;
      pc_r    <= 16'h0200;
      sp_r    <= '0;
      dt_r    <= 8'd0;
      st_r    <= 8'd0;
      hires_r <= 1'b0;
      halt_r  <= 1'b0;
    end else begin
      if (accept && in_operation == OP_TICK) begin
        if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
        if (st_r != 8'd0) st_r <= st_r - 8'd1;
      end
      if (accept && in_operation == OP_EXEC && !halt_r &&
          in_opcode[15:12] == 4'hF &&
          (nn == NN_BCD || nn == NN_STR || nn == NN_LDR)) begin
        pc_r <= pc2;
      end
      if (do_exec) begin
        pc_r    <= pop ? stack_q : pc_new;
        i_r     <= i_new;
        dt_r    <= dt_new;
        st_r    <= st_new;
        hires_r <= hires_new;
        halt_r  <= halt_new;
        if (push) sp_r <= sp_r + CW'(1);
        if (pop)  sp_r <= sp_r - CW'(1);
        if (vx_we) v_r[x] <= vx_new;
        if (vf_we) v_r[15] <= vf_new;
      end
      if (cmd.blk_ld_wr) v_r[cmd.step[3:0]] <= mem_q;
      if (cmd.blk_done) i_r <= i_r + {12'd0, opc_r[11:8]} + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opc_r  <= in_opcode;
      clr_r  <= 1'b0;
      draw_r <= 1'b0;
      wait_r <= 1'b0;
      dx_r   <= 8'd0;
      dy_r   <= 8'd0;
      stat_r <= ST_OK;
      if (do_exec) begin
        clr_r  <= clr_new;
        draw_r <= draw_new;
        wait_r <= wait_new;
        stat_r <= stat_new;
        if (draw_new) begin
          dx_r <= vx;
          dy_r <= vy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_program_counter <= pc_r;
      out_index_value     <= i_r;
      out_status          <= halt_r ? ST_HALTED : stat_r;
      out_clear_screen    <= clr_r;
      out_draw_request    <= draw_r;
      out_draw_x          <= dx_r;
      out_draw_y          <= dy_r;
      out_draw_rows       <= draw_r ? opc_r[3:0] : 4'd0;
      out_high_res        <= hires_r;
      out_sound_on        <= st_r != 8'd0;
      out_waiting_key     <= wait_r;
    end
  end

  `include "chip8_instruction_execute_assert.svh"
  `C8_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt left without reset")
  `C8_ASSERT_IMP(a_sp_bound, 1'b1, sp_r <= CW'(STACK_DEPTH), "stack pointer out of range")
  `C8_ASSERT_IMP(a_push_pop, do_exec, !(push && pop), "push and pop together")

endmodule

/* hdl/chip8_instruction_execute.sv */
// top level of the chip8 execute unit: config registers, controller, datapath
// depends on c8exe_pkg, c8exe_ctrl, c8exe_dp
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | operation, opcode, key_bits, random_byte, load_*
// out     | out_valid / out_ready| program_counter ... waiting_key
// cfg     | cfg_write            | cfg_index, cfg_data
//
// most words are applied in the cycle they are accepted, then captured in S_OUT before out_valid rises
// fx33 makes one memory write per bcd digit, in S_BCD, on the single memory port
// fx55 stores one register per S_ST step; fx65 alternates S_LDR and S_LDW: one register per memory access
// in_ready is low while a word is in work or a result waits to be taken
// reset is synchronous; memory and call stack contents are not cleared
module chip8_instruction_execute import c8exe_pkg::*; #(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int MEM_BYTES   = DefMemBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_key_bits,
  input  logic [7:0]  in_random_byte,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_program_counter,
  output logic [15:0] out_index_value,
  output logic [2:0]  out_status,
  output logic        out_clear_screen,
  output logic        out_draw_request,
  output logic [7:0]  out_draw_x,
  output logic [7:0]  out_draw_y,
  output logic [3:0]  out_draw_rows,
  output logic        out_high_res,
  output logic        out_sound_on,
  output logic        out_waiting_key,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  logic       vf_quirk_r, jump_vx_r;
  c8exe_cmd_t cmd;
  c8exe_sts_t sts;
  logic       capture;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_quirk_r <= 1'b0;
      jump_vx_r  <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_VF_RESET) vf_quirk_r <= cfg_data;
      else if (cfg_index == CFG_JUMP_VX) jump_vx_r <= cfg_data;
    end
  end

  c8exe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_opcode,
    .out_valid, .out_ready, .sts, .cmd, .capture
  );

  c8exe_dp #(.STACK_DEPTH(STACK_DEPTH), .MEM_BYTES(MEM_BYTES)) u_dp (
    .clk, .rst_n,
    .accept(in_valid && in_ready),
    .in_operation, .in_opcode, .in_key_bits, .in_random_byte,
    .in_load_address, .in_load_byte,
    .vf_reset_quirk(vf_quirk_r), .jump_uses_vx(jump_vx_r),
    .cmd, .capture, .sts,
    .out_program_counter, .out_index_value, .out_status, .out_clear_screen,
    .out_draw_request, .out_draw_x, .out_draw_y, .out_draw_rows,
    .out_high_res, .out_sound_on, .out_waiting_key
  );

endmodule

/* bench/tb_chip8_instruction_execute.sv */
// self-checking bench for the chip8 execute unit: directed table, then random words
// depends on c8exe_pkg and chip8_instruction_execute
module tb_chip8_instruction_execute;
  import c8exe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 620;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] opc;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic [11:0] addr;
    logic [7:0]  dat;
  } c8_word_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] idx;
    logic [2:0]  st;
    logic        clr;
    logic        draw;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [3:0]  rows;
    logic        hires;
    logic        snd;
    logic        key_wait;
  } exec_result_t;

  typedef struct packed {
    c8_word_t    w;
    logic        typed;
    logic [15:0] pc;
    logic [2:0]  st;
  } table_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_operation = '0;
  logic [15:0] in_opcode = '0, in_key_bits = '0;
  logic [7:0] in_random_byte = '0, in_load_byte = '0;
  logic [11:0] in_load_address = '0;
  logic out_valid, out_ready = 0;
  logic [15:0] out_program_counter, out_index_value;
  logic [2:0] out_status;
  logic out_clear_screen, out_draw_request, out_high_res, out_sound_on, out_waiting_key;
  logic [7:0] out_draw_x, out_draw_y;
  logic [3:0] out_draw_rows;
  logic cfg_write = 0, cfg_index = 0, cfg_data = 0;

  chip8_instruction_execute uut (.*);

  always #10 clk = ~clk;

  // shadow machine state
  logic [7:0]  vr [16];
  logic [15:0] ir, pcr;
  logic [15:0] stk [DefStackDepth];
  int unsigned depth;
  logic [7:0]  dly, snd;
  bit hires, halted;
  logic [7:0] mem [DefMemBytes];
  bit written [DefMemBytes];
  bit q_vf, q_jmp;

  exec_result_t pending[$];
  table_row_t dir_rows[$];
  int errors = 0;
  int cycles = 0;
  bit idle_en = 1;
  int hold_req = 0;

  function automatic void mem_put(logic [15:0] a, logic [7:0] d);
    mem[a[11:0]] = d;
    written[a[11:0]] = 1;
  endfunction

  function automatic exec_result_t apply_word(c8_word_t s);
    exec_result_t r;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, fl;
    logic [11:0] nnn;
    int k;
    bit set_fl;
    r = '0;
    x = s.opc[11:8]; y = s.opc[7:4]; n = s.opc[3:0];
    nn = s.opc[7:0]; nnn = s.opc[11:0];
    vx = vr[x]; vy = vr[y];
    if (s.op == OP_LOAD) begin
      mem[s.addr] = s.dat;
      written[s.addr] = 1;
    end else if (s.op == OP_TICK) begin
      if (dly != 0) dly--;
      if (snd != 0) snd--;
    end else if (s.op == OP_EXEC && !halted) begin
      pcr = pcr + 16'd2;
      case (s.opc[15:12])
        4'h0: begin
          if (s.opc == OPC_CLS) r.clr = 1;
          else if (s.opc == OPC_RET) begin
            if (depth == 0) r.st = ST_UNDERFLOW;
            else begin
              depth--;
              pcr = stk[depth];
            end
          end else if (s.opc == OPC_EXIT) halted = 1;
          else if (s.opc == OPC_HIGH) hires = 1;
          else if (s.opc == OPC_LOW) hires = 0;
          else r.st = ST_UNKNOWN;
        end
        4'h1: pcr = {4'h0, nnn};
        4'h2: begin
          if (depth >= DefStackDepth) r.st = ST_OVERFLOW;
          else begin
            stk[depth] = pcr;
            depth++;
            pcr = {4'h0, nnn};
          end
        end
        4'h3: if (vx == nn) pcr = pcr + 16'd2;
        4'h4: if (vx != nn) pcr = pcr + 16'd2;
        4'h5: if (vx == vy) pcr = pcr + 16'd2;
        4'h6: vr[x] = nn;
        4'h7: vr[x] = vx + nn;
        4'h8: begin
          set_fl = 1;
          fl = 0;
          case (n)
            4'h0: begin vr[x] = vy; set_fl = 0; end
            4'h1: begin vr[x] = vx | vy; set_fl = q_vf; end
            4'h2: begin vr[x] = vx & vy; set_fl = q_vf; end
            4'h3: begin vr[x] = vx ^ vy; set_fl = q_vf; end
            4'h4: begin fl = ({1'b0, vx} + {1'b0, vy}) > 9'hFF; vr[x] = vx + vy; end
            4'h5: begin fl = vx >= vy; vr[x] = vx - vy; end
            4'h6: begin fl = vy[0]; vr[x] = vy >> 1; end
            4'h7: begin fl = vy >= vx; vr[x] = vy - vx; end
            4'hE: begin fl = vy[7]; vr[x] = vy << 1; end
            default: begin r.st = ST_UNKNOWN; set_fl = 0; end
          endcase
          // flag written last so it wins when x is vf
          if (set_fl) vr[15] = fl;
        end
        4'h9: if (vx != vy) pcr = pcr + 16'd2;
        4'hA: ir = {4'h0, nnn};
        4'hB: pcr = {4'h0, nnn} + vr[q_jmp ? x : 4'h0];
        4'hC: vr[x] = s.rnd & nn;
        4'hD: begin
          r.draw = 1; r.dx = vx; r.dy = vy; r.rows = n;
        end
        4'hE: begin
          if (nn == NN_SKP) begin
            if (s.keys[vx[3:0]]) pcr = pcr + 16'd2;
          end else if (nn == NN_SKNP) begin
            if (!s.keys[vx[3:0]]) pcr = pcr + 16'd2;
          end else r.st = ST_UNKNOWN;
        end
        default: begin
          case (nn)
            NN_GDT: vr[x] = dly;
            NN_KEY: begin
              k = 16;
              for (int i = 15; i >= 0; i--) if (s.keys[i]) k = i;
              if (k < 16) vr[x] = 8'(k);
              else begin
                pcr = pcr - 16'd2;
                r.key_wait = 1;
              end
            end
            NN_SDT: dly = vx;
            NN_SST: snd = vx;
            NN_ADDI: ir = ir + {8'h0, vx};
            NN_FONT: ir = FONT_BASE + 16'(vx) * 16'd5;
            NN_BCD: begin
              mem_put(ir, vx / 100);
              mem_put(ir + 16'd1, (vx / 10) % 10);
              mem_put(ir + 16'd2, vx % 10);
            end
            NN_STR: begin
              for (int i = 0; i <= x; i++) mem_put(ir + 16'(i), vr[i]);
              ir = ir + 16'(x) + 16'd1;
            end
            NN_LDR: begin
              for (int i = 0; i <= x; i++) vr[i] = mem[12'(ir + 16'(i))];
              ir = ir + 16'(x) + 16'd1;
            end
            default: r.st = ST_UNKNOWN;
          endcase
        end
      endcase
    end
    if (halted) r.st = ST_HALTED;
    r.pc = pcr;
    r.idx = ir;
    r.hires = hires;
    r.snd = snd != 0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  // result side: check every accepted word against the oldest expectation
  always @(posedge clk) begin : result_check
    exec_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) report("unexpected word", out_program_counter, 0);
      else begin
        e = pending.pop_front();
        if (out_program_counter !== e.pc) report("program_counter", out_program_counter, e.pc);
        if (out_index_value !== e.idx) report("index_value", out_index_value, e.idx);
        if (out_status !== e.st) report("status", out_status, e.st);
        if (out_clear_screen !== e.clr) report("clear_screen", out_clear_screen, e.clr);
        if (out_draw_request !== e.draw) report("draw_request", out_draw_request, e.draw);
        if (out_draw_x !== e.dx) report("draw_x", out_draw_x, e.dx);
        if (out_draw_y !== e.dy) report("draw_y", out_draw_y, e.dy);
        if (out_draw_rows !== e.rows) report("draw_rows", out_draw_rows, e.rows);
        if (out_high_res !== e.hires) report("high_res", out_high_res, e.hires);
        if (out_sound_on !== e.snd) report("sound_on", out_sound_on, e.snd);
        if (out_waiting_key !== e.key_wait) report("waiting_key", out_waiting_key, e.key_wait);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        out_ready <= 0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(c8_word_t w, bit typed = 0, logic [15:0] pc = '0,
                           logic [2:0] st = '0);
    exec_result_t r;
    in_valid <= 1;
    in_operation <= w.op;
    in_opcode <= w.opc;
    in_key_bits <= w.keys;
    in_random_byte <= w.rnd;
    in_load_address <= w.addr;
    in_load_byte <= w.dat;
    do @(posedge clk); while (!in_ready);
    r = apply_word(w);
    if (typed) begin
      r.pc = pc;
      r.st = st;
    end
    pending.insert(pending.size(), r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // drop valid first so the last word is not offered again while waiting
  task automatic drain();
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(bit vf, bit jmp);
    cfg_write <= 1; cfg_index <= CFG_VF_RESET; cfg_data <= vf;
    @(posedge clk);
    cfg_index <= CFG_JUMP_VX; cfg_data <= jmp;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    q_vf = vf;
    q_jmp = jmp;
  endtask

  function automatic c8_word_t mk(logic [1:0] op, logic [15:0] opc, logic [15:0] keys = 0,
                                  logic [7:0] rnd = 0, logic [11:0] addr = 0,
                                  logic [7:0] dat = 0);
    c8_word_t w;
    w.op = op; w.opc = opc; w.keys = keys; w.rnd = rnd; w.addr = addr; w.dat = dat;
    return w;
  endfunction

  function automatic void add_row(c8_word_t w, bit typed, logic [15:0] pc, logic [2:0] st);
    table_row_t row;
    row.w = w;
    row.typed = typed;
    row.pc = pc;
    row.st = st;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic c8_word_t random_word();
    c8_word_t w;
    logic [7:0] sys_nn [5];
    logic [7:0] f_nn [9];
    bit ok;
    int sel;
    sys_nn = '{OPC_CLS[7:0], OPC_RET[7:0], OPC_HIGH[7:0], OPC_LOW[7:0], 8'h00};
    f_nn = '{NN_GDT, NN_KEY, NN_SDT, NN_SST, NN_ADDI, NN_FONT, NN_BCD, NN_STR, NN_LDR};
    w = mk(OP_EXEC, 16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) == 0) w.keys = 0;
    sel = $urandom_range(0, 99);
    if (sel < 10) w.op = OP_LOAD;
    else if (sel < 15) w.op = OP_TICK;
    else if (sel < 17) w.op = OP_SPARE;
    else if (sel < 25) w.opc[15:12] = 4'h6;
    else begin
      case (w.opc[15:12])
        4'h0: if ($urandom_range(0, 3) != 0) w.opc = {8'h00, sys_nn[$urandom_range(0, 4)]};
        4'h8: if ($urandom_range(0, 7) != 0) begin
          sel = $urandom_range(0, 8);
          w.opc[3:0] = sel == 8 ? 4'hE : 4'(sel);
        end
        4'hE: if ($urandom_range(0, 5) != 0) w.opc[7:0] = $urandom_range(0, 1) ? NN_SKP : NN_SKNP;
        4'hF: if ($urandom_range(0, 7) != 0) w.opc[7:0] = f_nn[$urandom_range(0, 8)];
        default: ;
      endcase
    end
    // halt is saved for the end of the run
    if (w.opc == OPC_EXIT) w.opc = OPC_CLS;
    // never read memory that was never written: store instead
    if (w.op == OP_EXEC && w.opc[15:12] == 4'hF && w.opc[7:0] == NN_LDR) begin
      ok = 1;
      for (int i = 0; i <= w.opc[11:8]; i++) if (!written[12'(ir + 16'(i))]) ok = 0;
      if (!ok) w.opc[7:0] = NN_STR;
    end
    return w;
  endfunction

  // count covers every word sent, call chains included
  task automatic random_phase(int count);
    int sent;
    int rets;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 39) == 0) begin
        // call chain deep enough to overflow the stack, then unwind
        rets = $urandom_range(1, DefStackDepth + 2);
        repeat (DefStackDepth + 2) send_word(mk(OP_EXEC, {4'h2, 12'($urandom)}));
        repeat (rets) send_word(mk(OP_EXEC, OPC_RET));
        sent += DefStackDepth + 2 + rets;
      end else begin
        send_word(random_word());
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) vr[i] = 0;
    for (int i = 0; i < DefMemBytes; i++) written[i] = 0;
    ir = 0; pcr = 16'h0200; depth = 0; dly = 0; snd = 0;
    hires = 0; halted = 0; q_vf = 0; q_jmp = 0;

    // typed rows first: pc and status can be read off directly from reset
    add_row(mk(OP_EXEC, 16'h6005), 1, 16'h0202, ST_OK);
    add_row(mk(OP_EXEC, OPC_RET), 1, 16'h0204, ST_UNDERFLOW);
    add_row(mk(OP_EXEC, 16'h0123), 1, 16'h0206, ST_UNKNOWN);
    add_row(mk(OP_EXEC, 16'h8008), 1, 16'h0208, ST_UNKNOWN);
    add_row(mk(OP_EXEC, 16'hE0FF), 1, 16'h020A, ST_UNKNOWN);
    add_row(mk(OP_EXEC, 16'hF0FF), 1, 16'h020C, ST_UNKNOWN);
    add_row(mk(OP_LOAD, 0, 0, 0, 12'hFFF, 8'hFF), 1, 16'h020C, ST_OK);
    add_row(mk(OP_LOAD, 0, 16'hFFFF, 8'hFF, 12'h000, 8'h00), 1, 16'h020C, ST_OK);
    add_row(mk(OP_SPARE, 16'hFFFF), 1, 16'h020C, ST_OK);
    add_row(mk(OP_EXEC, OPC_CLS), 0, 0, 0);
    add_row(mk(OP_EXEC, OPC_HIGH), 0, 0, 0);
    add_row(mk(OP_EXEC, OPC_LOW), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h6AFF), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h6BFF), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h8AB4), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h8FA4), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h8AB5), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h8AB6), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h8AB7), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h8ABE), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hAFFE), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hFB33), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hFF55), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hA000), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hF065), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hFB18), 0, 0, 0);
    add_row(mk(OP_TICK, 0), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hF00A, 16'h0000), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hF00A, 16'h8000), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hE09E, 16'h8000), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hE0A1, 16'h7FFF), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'h2FFF), 0, 0, 0);
    add_row(mk(OP_EXEC, OPC_RET), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hDAB0), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hC3FF, 0, 8'hA5), 0, 0, 0);
    add_row(mk(OP_EXEC, 16'hBFFF), 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_cfg(0, 0);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].pc,
                                    dir_rows[i].st);
    drain();

    write_cfg(1, 1);
    random_phase(RANDOM_WORDS / 4);
    drain();

    // long receiver hold-off while words keep coming
    write_cfg(0, 1);
    hold_req = 300;
    random_phase(RANDOM_WORDS / 4);
    drain();

    write_cfg(1, 0);
    random_phase(RANDOM_WORDS / 4);
    drain();

    // last stretch runs with no idling
    write_cfg(0, 0);
    idle_en = 0;
    random_phase(RANDOM_WORDS / 4);
    send_word(mk(OP_EXEC, OPC_EXIT));
    send_word(mk(OP_EXEC, 16'h6123));
    send_word(mk(OP_LOAD, 0, 0, 0, 12'h123, 8'h5A));
    send_word(mk(OP_TICK, 0));
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
